// ===== hdl/rhwm_pkg.sv =====
// Package for the rolling hash window matcher.
// Holds the hash constants, the modular reduction constants, the digit mapping and
// the command and status types shared by the controller and the datapath.
package rhwm_pkg;

  localparam int unsigned HASH_W    = 14;
  localparam int unsigned PROD_W    = 28;
  localparam int unsigned QUOT_W    = 15;
  localparam int unsigned MULT_W    = 29;
  localparam int unsigned RED_SHIFT = 42;
  localparam int unsigned FOLD_W    = 19;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 14;

  localparam logic [HASH_W-1:0] HASH_MOD     = 14'd11932;
  localparam logic [4:0]        HASH_BASE    = 5'd26;
  localparam logic [7:0]        DIGIT_OFFSET = 8'd96;

  // Barrett reciprocal of the modulus; leaves a remainder below twice the modulus.
  localparam logic [MULT_W-1:0] RED_MULT =
    MULT_W'((64'd1 << RED_SHIFT) / 64'(HASH_MOD));

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HASH = 1'b1;

  localparam logic [1:0] RED_DEST_SUB  = 2'd0;
  localparam logic [1:0] RED_DEST_HASH = 2'd1;
  localparam logic [1:0] RED_DEST_LEAD = 2'd2;

  typedef struct packed {
    logic       cfg_len;
    logic       cfg_pat;
    logic       accept;
    logic       lead_load;
    logic       mul;
    logic       fold;
    logic       red_quot;
    logic       red_rem;
    logic [1:0] red_dest;
    logic       emit;
  } rhwm_cmd_t;

  typedef struct packed {
    logic lead_done;
    logic out_free;
  } rhwm_status_t;

  function automatic logic [HASH_W-1:0] digit_of(input logic [7:0] b);
    if (b >= DIGIT_OFFSET) begin
      return HASH_W'(b - DIGIT_OFFSET);
    end else begin
      return HASH_W'(b) + HASH_MOD - HASH_W'(DIGIT_OFFSET);
    end
  endfunction

endpackage

// ===== hdl/rhwm_ctrl.sv =====
// Controller of the rolling hash window matcher.
// Sequences configuration, weight recomputation and the per-byte hash update.
// Depends on rhwm_pkg for the command and status types.
module rhwm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [rhwm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  output logic                            cfg_ready_o,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rhwm_pkg::rhwm_status_t          status_i,
  output rhwm_pkg::rhwm_cmd_t             cmd_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_LEAD_CHK  = 4'd1;
  localparam logic [3:0] ST_LEAD_QUOT = 4'd2;
  localparam logic [3:0] ST_LEAD_REM  = 4'd3;
  localparam logic [3:0] ST_MUL       = 4'd4;
  localparam logic [3:0] ST_SUB_QUOT  = 4'd5;
  localparam logic [3:0] ST_SUB_REM   = 4'd6;
  localparam logic [3:0] ST_FOLD      = 4'd7;
  localparam logic [3:0] ST_HASH_QUOT = 4'd8;
  localparam logic [3:0] ST_HASH_REM  = 4'd9;
  localparam logic [3:0] ST_EMIT      = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cfg_ready_o = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          if (cfg_index_i == rhwm_pkg::CFG_WINDOW_LEN) begin
            cmd_o.cfg_len = 1'b1;
            state_d       = ST_LEAD_CHK;
          end else begin
            cmd_o.cfg_pat = 1'b1;
          end
        end else if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_LEAD_CHK: begin
        if (status_i.lead_done) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.lead_load = 1'b1;
          state_d         = ST_LEAD_QUOT;
        end
      end
      ST_LEAD_QUOT: begin
        cmd_o.red_quot = 1'b1;
        state_d        = ST_LEAD_REM;
      end
      ST_LEAD_REM: begin
        cmd_o.red_rem  = 1'b1;
        cmd_o.red_dest = rhwm_pkg::RED_DEST_LEAD;
        state_d        = ST_LEAD_CHK;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUB_QUOT;
      end
      ST_SUB_QUOT: begin
        cmd_o.red_quot = 1'b1;
        state_d        = ST_SUB_REM;
      end
      ST_SUB_REM: begin
        cmd_o.red_rem  = 1'b1;
        cmd_o.red_dest = rhwm_pkg::RED_DEST_SUB;
        state_d        = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_HASH_QUOT;
      end
      ST_HASH_QUOT: begin
        cmd_o.red_quot = 1'b1;
        state_d        = ST_HASH_REM;
      end
      ST_HASH_REM: begin
        cmd_o.red_rem  = 1'b1;
        cmd_o.red_dest = rhwm_pkg::RED_DEST_HASH;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/rhwm_datapath.sv =====
// Datapath of the rolling hash window matcher.
// Holds the window delay line, the shared Barrett reduction unit, the hash,
// the counters and the result register. Depends on rhwm_pkg.
module rhwm_datapath #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rhwm_pkg::rhwm_cmd_t                cmd_i,
  output rhwm_pkg::rhwm_status_t             status_o,
  input  logic [rhwm_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  logic [7:0]                         text_byte_i,
  input  logic                               end_of_text_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               is_match_o,
  output logic [rhwm_pkg::OUT_W-1:0]         window_index_o,
  output logic [rhwm_pkg::OUT_W-1:0]         match_count_o,
  output logic                               final_res_o
);

  localparam int unsigned AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned PW      = (AW + 1 > rhwm_pkg::LEN_W) ? AW + 1 : rhwm_pkg::LEN_W;
  localparam int unsigned LEN_CAP = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
  localparam int unsigned HW      = rhwm_pkg::HASH_W;
  localparam int unsigned OW      = rhwm_pkg::OUT_W;

  logic [7:0] win_mem [MAX_WINDOW];

  logic [rhwm_pkg::LEN_W-1:0]  win_len_q;
  logic [HW-1:0]               pat_q;
  logic [HW-1:0]               lead_q;
  logic [rhwm_pkg::LEN_W-1:0]  lead_cnt_q;
  logic [AW-1:0]               wp_q;
  logic [HW-1:0]               hash_q;
  logic [COUNT_WIDTH-1:0]      bytes_q;
  logic [COUNT_WIDTH-1:0]      matches_q;
  logic                        out_valid_q;

  logic [7:0]                  byte_q;
  logic [7:0]                  old_q;
  logic                        last_q;
  logic                        full_q;
  logic [rhwm_pkg::PROD_W-1:0] prod_q;
  logic [rhwm_pkg::QUOT_W-1:0] quot_q;
  logic [HW-1:0]               sub_q;
  logic                        is_match_q;
  logic [OW-1:0]               window_index_q;
  logic [OW-1:0]               match_count_q;
  logic                        final_res_q;

  logic [rhwm_pkg::LEN_W-1:0]        eff_len;
  logic [COUNT_WIDTH-1:0]            eff_len_c;
  logic [PW-1:0]                     wp_inc;
  logic [AW-1:0]                     wp_next;
  logic [rhwm_pkg::PROD_W-1:0]       mul_prod;
  logic [rhwm_pkg::FOLD_W-1:0]       lead_x;
  logic [rhwm_pkg::PROD_W+rhwm_pkg::MULT_W-1:0] quot_prod;
  logic [rhwm_pkg::PROD_W:0]         qm_prod;
  logic [rhwm_pkg::PROD_W:0]         rem_raw;
  logic [rhwm_pkg::PROD_W:0]         rem_fix;
  logic [HW:0]                       h1_raw;
  logic [HW-1:0]                     h1;
  logic [rhwm_pkg::FOLD_W-1:0]       fold_x;
  logic                              full_after;
  logic                              hit;
  logic [COUNT_WIDTH-1:0]            matches_next;
  logic [COUNT_WIDTH-1:0]            win_idx_full;
  logic [COUNT_WIDTH+OW-1:0]         idx_ext;
  logic [COUNT_WIDTH+OW-1:0]         cnt_ext;
  logic                              produced;

  always_comb begin
    if (win_len_q == '0) begin
      eff_len = rhwm_pkg::LEN_W'(1);
    end else if (win_len_q > rhwm_pkg::LEN_W'(LEN_CAP)) begin
      eff_len = rhwm_pkg::LEN_W'(LEN_CAP);
    end else begin
      eff_len = win_len_q;
    end
  end

  assign eff_len_c = COUNT_WIDTH'(eff_len);
  assign wp_inc    = PW'(wp_q) + PW'(1);
  assign wp_next   = (wp_inc == PW'(eff_len)) ? '0 : wp_inc[AW-1:0];

  assign mul_prod  = rhwm_pkg::PROD_W'(rhwm_pkg::digit_of(old_q)) * rhwm_pkg::PROD_W'(lead_q);
  assign lead_x    = rhwm_pkg::FOLD_W'(lead_q) * rhwm_pkg::FOLD_W'(rhwm_pkg::HASH_BASE);

  assign quot_prod = (rhwm_pkg::PROD_W+rhwm_pkg::MULT_W)'(prod_q)
                   * (rhwm_pkg::PROD_W+rhwm_pkg::MULT_W)'(rhwm_pkg::RED_MULT);
  assign qm_prod   = (rhwm_pkg::PROD_W+1)'(quot_q) * (rhwm_pkg::PROD_W+1)'(rhwm_pkg::HASH_MOD);
  assign rem_raw   = {1'b0, prod_q} - qm_prod;
  assign rem_fix   = (rem_raw >= (rhwm_pkg::PROD_W+1)'(rhwm_pkg::HASH_MOD))
                   ? rem_raw - (rhwm_pkg::PROD_W+1)'(rhwm_pkg::HASH_MOD) : rem_raw;

  assign h1_raw = {1'b0, hash_q} + {1'b0, rhwm_pkg::HASH_MOD} - {1'b0, sub_q};
  assign h1     = (h1_raw >= {1'b0, rhwm_pkg::HASH_MOD})
                ? HW'(h1_raw - {1'b0, rhwm_pkg::HASH_MOD}) : h1_raw[HW-1:0];
  assign fold_x = rhwm_pkg::FOLD_W'(h1) * rhwm_pkg::FOLD_W'(rhwm_pkg::HASH_BASE)
                + rhwm_pkg::FOLD_W'(rhwm_pkg::digit_of(byte_q));

  assign full_after   = (bytes_q >= eff_len_c);
  assign hit          = (hash_q == pat_q);
  assign matches_next = (hit && (matches_q != '1)) ? matches_q + COUNT_WIDTH'(1) : matches_q;
  assign win_idx_full = bytes_q - eff_len_c;
  assign idx_ext      = {OW'(0), win_idx_full};
  assign cnt_ext      = {OW'(0), matches_next};
  assign produced     = full_after | last_q;

  assign status_o.lead_done = (lead_cnt_q >= eff_len);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      win_mem[wp_q] <= text_byte_i;
      old_q         <= win_mem[wp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= text_byte_i;
      last_q <= end_of_text_i;
      full_q <= (bytes_q >= eff_len_c);
    end
    if (cmd_i.mul) begin
      prod_q <= full_q ? mul_prod : '0;
    end else if (cmd_i.lead_load) begin
      prod_q <= rhwm_pkg::PROD_W'(lead_x);
    end else if (cmd_i.fold) begin
      prod_q <= rhwm_pkg::PROD_W'(fold_x);
    end
    if (cmd_i.red_quot) begin
      quot_q <= quot_prod[rhwm_pkg::RED_SHIFT +: rhwm_pkg::QUOT_W];
    end
    if (cmd_i.red_rem && (cmd_i.red_dest == rhwm_pkg::RED_DEST_SUB)) begin
      sub_q <= rem_fix[HW-1:0];
    end
    if (cmd_i.emit) begin
      is_match_q     <= full_after & hit;
      window_index_q <= full_after ? idx_ext[OW-1:0] : '0;
      match_count_q  <= full_after ? cnt_ext[OW-1:0] : '0;
      final_res_q    <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= rhwm_pkg::LEN_W'(1);
      pat_q       <= '0;
      lead_q      <= HW'(1);
      lead_cnt_q  <= rhwm_pkg::LEN_W'(1);
      wp_q        <= '0;
      hash_q      <= '0;
      bytes_q     <= '0;
      matches_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= produced;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.cfg_len) begin
        win_len_q  <= cfg_data_i[rhwm_pkg::LEN_W-1:0];
        lead_q     <= HW'(1);
        lead_cnt_q <= rhwm_pkg::LEN_W'(1);
        wp_q       <= '0;
        hash_q     <= '0;
        bytes_q    <= '0;
        matches_q  <= '0;
      end
      if (cmd_i.cfg_pat) begin
        pat_q <= cfg_data_i[HW-1:0];
      end
      if (cmd_i.accept) begin
        wp_q <= wp_next;
      end
      if (cmd_i.red_rem && (cmd_i.red_dest == rhwm_pkg::RED_DEST_LEAD)) begin
        lead_q     <= rem_fix[HW-1:0];
        lead_cnt_q <= lead_cnt_q + rhwm_pkg::LEN_W'(1);
      end
      if (cmd_i.red_rem && (cmd_i.red_dest == rhwm_pkg::RED_DEST_HASH)) begin
        hash_q <= rem_fix[HW-1:0];
        if (bytes_q != '1) begin
          bytes_q <= bytes_q + COUNT_WIDTH'(1);
        end
      end
      if (cmd_i.emit) begin
        if (last_q) begin
          wp_q      <= '0;
          hash_q    <= '0;
          bytes_q   <= '0;
          matches_q <= '0;
        end else if (full_after) begin
          matches_q <= matches_next;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_match_o     = is_match_q;
  assign window_index_o = window_index_q;
  assign match_count_o  = match_count_q;
  assign final_res_o    = final_res_q;

endmodule

// ===== hdl/rolling_hash_window_matcher.sv =====
// Top level of the rolling hash window matcher: one text byte per transaction.
// Each byte passes twice through the shared Barrett reduction unit; no new byte is
// accepted until the previous result is emitted, which can stall on out_ready_i.
// A window_len write recomputes the leading weight by L - 1 multiply and reduce steps,
// where L is window_len clamped to the range 1 to the lesser of MAX_WINDOW and 127.
// Reset sets window_len to 1, pattern_hash to 0 and clears the stream state.
// Depends on rhwm_pkg, rhwm_ctrl and rhwm_datapath.
module rolling_hash_window_matcher #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rhwm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rhwm_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        text_byte_i,
  input  logic                              end_of_text_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              is_match_o,
  output logic [rhwm_pkg::OUT_W-1:0]        window_index_o,
  output logic [rhwm_pkg::OUT_W-1:0]        match_count_o,
  output logic                              final_res_o
);

  rhwm_pkg::rhwm_cmd_t    cmd;
  rhwm_pkg::rhwm_status_t status;

  rhwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rhwm_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_data_i     (cfg_data_i),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .is_match_o     (is_match_o),
    .window_index_o (window_index_o),
    .match_count_o  (match_count_o),
    .final_res_o    (final_res_o)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rolling_hash_window_matcher, the rolling hash window matcher.
// A queue-fed driver, a monitor with a built-in hash predictor, and a watchdog check results.
// Depends on rhwm_pkg and the rolling_hash_window_matcher RTL.
module testbench;

  localparam int unsigned MAX_WIN        = 64;
  localparam int unsigned MODULUS        = 11932;
  localparam int unsigned RADIX          = 26;
  localparam int unsigned CHAR_BIAS      = 96;
  localparam longint unsigned COUNT_MAX  = (64'd1 << 24) - 1;
  localparam logic [7:0] LETTER_A        = 8'd97;
  localparam int unsigned ITEM_TARGET    = 650;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic                       is_match;
    logic [rhwm_pkg::OUT_W-1:0] window_index;
    logic [rhwm_pkg::OUT_W-1:0] match_count;
    logic                       final_res;
  } hash_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [rhwm_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [rhwm_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [7:0]                     text_byte_i = 8'h00;
  logic                           end_of_text_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b1;
  logic                           is_match_o;
  logic [rhwm_pkg::OUT_W-1:0]     window_index_o;
  logic [rhwm_pkg::OUT_W-1:0]     match_count_o;
  logic                           final_res_o;

  text_item_t   text_q[$];
  hash_result_t expected_q[$];
  logic [7:0]   pattern_q[$];
  int           pending_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  fail_count = 0;

  logic [7:0]      window_mem [MAX_WIN] = '{default: 8'h00};
  int unsigned     wr_slot = 0;
  int unsigned     hash_acc = 0;
  longint unsigned seen_cnt = 0;
  longint unsigned match_cnt = 0;
  int unsigned     lead_w = 1;
  logic [6:0]      len_reg = 7'd1;
  logic [13:0]     pat_reg = 14'd0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] ready_mask = 16'hFFFF;
  int unsigned mask_age = 0;
  int unsigned idle_cycles = 0;

  rolling_hash_window_matcher uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_window(input logic [6:0] len);
    if (len == 0) return 1;
    if (len > MAX_WIN) return MAX_WIN;
    return 32'(len);
  endfunction

  function automatic int unsigned char_digit(input logic [7:0] ch);
    return (int'(ch) + MODULUS - CHAR_BIAS) % MODULUS;
  endfunction

  function automatic int unsigned pattern_hash_of();
    int unsigned h;
    h = 0;
    foreach (pattern_q[k]) h = (h * RADIX + char_digit(pattern_q[k])) % MODULUS;
    return h;
  endfunction

  function automatic void restart_text();
    wr_slot = 0;
    hash_acc = 0;
    seen_cnt = 0;
    match_cnt = 0;
  endfunction

  function automatic void apply_reg_write(input logic [rhwm_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [rhwm_pkg::CFG_DAT_W-1:0] data);
    if (idx == rhwm_pkg::CFG_WINDOW_LEN) begin
      len_reg = data[6:0];
      lead_w = 1;
      for (int unsigned i = 1; i < eff_window(len_reg); i++) lead_w = (lead_w * RADIX) % MODULUS;
      restart_text();
    end else if (idx == rhwm_pkg::CFG_PATTERN_HASH) begin
      pat_reg = data;
    end
  endfunction

  function automatic void predict_window(input text_item_t it);
    int unsigned  n;
    int unsigned  slot;
    int unsigned  h;
    hash_result_t r;
    n = eff_window(len_reg);
    slot = wr_slot % n;
    h = hash_acc;
    if (seen_cnt >= n) begin
      h = (h + MODULUS - (char_digit(window_mem[slot]) * lead_w) % MODULUS) % MODULUS;
    end
    hash_acc = (h * RADIX + char_digit(it.ch)) % MODULUS;
    window_mem[slot] = it.ch;
    wr_slot = (slot + 1) % n;
    if (seen_cnt < COUNT_MAX) seen_cnt++;
    if (seen_cnt >= n) begin
      r.is_match = (hash_acc == pat_reg);
      if (r.is_match && match_cnt < COUNT_MAX) match_cnt++;
      r.window_index = rhwm_pkg::OUT_W'(seen_cnt - n);
      r.match_count = rhwm_pkg::OUT_W'(match_cnt);
      r.final_res = it.eot;
      expected_q.push_back(r);
    end else if (it.eot) begin
      r = '0;
      r.final_res = 1'b1;
      expected_q.push_back(r);
    end
    if (it.eot) restart_text();
  endfunction

  task automatic push_item(input logic [7:0] ch, input logic eot);
    text_q.push_back('{ch: ch, eot: eot});
    pending_count++;
    items_sent++;
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], i == s.len() - 1);
  endtask

  task automatic push_text(input int unsigned n_chars, input bit noisy, input bit terminate);
    logic [7:0] chars[$];
    while (chars.size() < n_chars) begin
      if (!noisy && $urandom_range(0, 3) == 0 && chars.size() + pattern_q.size() <= n_chars) begin
        foreach (pattern_q[k]) chars.push_back(pattern_q[k]);
      end else if (noisy) begin
        chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        chars.push_back(LETTER_A + 8'($urandom_range(0, 2)));
      end
    end
    foreach (chars[k]) push_item(chars[k], terminate && k == chars.size() - 1);
  endtask

  task automatic write_reg(input logic [rhwm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rhwm_pkg::CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_count != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    text_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (text_q.size() != 0) begin
        nxt = text_q.pop_front();
        in_valid_i <= 1'b1;
        text_byte_i <= nxt.ch;
        end_of_text_i <= nxt.eot;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    hash_result_t want;
    bit progress;
    progress = 1'b0;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      apply_reg_write(cfg_index_i, cfg_data_i);
      progress = 1'b1;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_window('{ch: text_byte_i, eot: end_of_text_i});
      pending_count--;
      progress = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      progress = 1'b1;
      if (expected_q.size() == 0) begin
        $error("Unexpected result transaction at window_index %0d.", window_index_o);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (is_match_o !== want.is_match) begin
          $error("is_match: expected %0d, actual %0d", want.is_match, is_match_o);
          fail_count++;
        end
        if (window_index_o !== want.window_index) begin
          $error("window_index: expected %0d, actual %0d", want.window_index, window_index_o);
          fail_count++;
        end
        if (match_count_o !== want.match_count) begin
          $error("match_count: expected %0d, actual %0d", want.match_count, match_count_o);
          fail_count++;
        end
        if (final_res_o !== want.final_res) begin
          $error("final_res: expected %0d, actual %0d", want.final_res, final_res_o);
          fail_count++;
        end
      end
    end
    mask_age++;
    if (mask_age == 150) begin
      mask_age = 0;
      ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
    out_ready_i <= ready_mask[0];
    ready_mask = {ready_mask[0], ready_mask[15:1]};
    if (progress) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int unsigned                    phase;
    int unsigned                    cur_len;
    int unsigned                    n_texts;
    int unsigned                    n_chars;
    logic [rhwm_pkg::CFG_DAT_W-1:0] len_data;
    logic [rhwm_pkg::CFG_DAT_W-1:0] pat_data;
    logic [rhwm_pkg::CFG_DAT_W-1:0] forced_len [4];
    forced_len = '{14'd64, 14'd0, 14'd127, 14'd1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: one-byte window, and digit zero matches the zero pattern hash.
    push_item(8'd96, 1'b0);
    push_item(8'd0, 1'b0);
    push_item(8'd255, 1'b0);
    push_item(LETTER_A, 1'b1);
    wait_idle();
    write_reg(rhwm_pkg::CFG_WINDOW_LEN, 14'd0);
    push_item(8'd122, 1'b0);
    push_item(8'h80, 1'b1);
    wait_idle();
    // The hash of "abca" is 7075.
    write_reg(rhwm_pkg::CFG_WINDOW_LEN, 14'd4);
    write_reg(rhwm_pkg::CFG_PATTERN_HASH, 14'd7075);
    push_string("xabcaq");
    push_string("ab");
    push_string("k");
    wait_idle();
    write_reg(rhwm_pkg::CFG_PATTERN_HASH, 14'h3FFF);
    push_string("abcab");

    cur_len = 4;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      if (phase < 4) begin
        len_data = forced_len[phase];
      end else begin
        case ($urandom_range(0, 7))
          0: len_data = 14'd0;
          1: len_data = 14'd1;
          2: len_data = 14'd64;
          3: len_data = 14'($urandom_range(65, 127));
          default: len_data = 14'($urandom_range(2, 16));
        endcase
      end
      if ($urandom_range(0, 3) == 0) len_data[13:7] = 7'($urandom);
      if (phase < 4 || $urandom_range(0, 4) != 0) begin
        write_reg(rhwm_pkg::CFG_WINDOW_LEN, len_data);
        cur_len = eff_window(len_data[6:0]);
      end
      pattern_q.delete();
      repeat (cur_len) pattern_q.push_back(LETTER_A + 8'($urandom_range(0, 2)));
      case ($urandom_range(0, 9))
        0: pat_data = 14'd0;
        1: pat_data = 14'd11931;
        2: pat_data = 14'($urandom_range(11932, 16383));
        3: pat_data = 14'($urandom_range(0, 11931));
        default: pat_data = 14'(pattern_hash_of());
      endcase
      write_reg(rhwm_pkg::CFG_PATTERN_HASH, pat_data);
      n_texts = $urandom_range(2, 4);
      for (int unsigned t = 0; t < n_texts; t++) begin
        n_chars = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cur_len)
                                              : $urandom_range(1, cur_len + 12);
        push_text(n_chars, $urandom_range(0, 6) == 0,
                  t != n_texts - 1 || $urandom_range(0, 4) != 0);
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rhwm_pkg.sv
hdl/rhwm_ctrl.sv
hdl/rhwm_datapath.sv
hdl/rolling_hash_window_matcher.sv
test/testbench.sv
